### design/sabd_pkg.sv
// Package for the block ADPCM decoder: widths, header codes, queue item type
// and the prediction coefficient tables. Depends on nothing.
`timescale 1ns / 1ps

package sabd_pkg;

  localparam int HIST_W  = 40;  // history word, signed fixed point
  localparam int COEF_W  = 8;   // signed coefficient in 64ths
  localparam int COEF_SH = 6;   // coefficient fraction bits
  localparam int POS_W   = 4;   // byte position within a block
  localparam int SAMP_W  = 16;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  // block header codes
  localparam logic [POS_W-1:0] POS_HEADER = 4'd0;
  localparam logic [POS_W-1:0] POS_FLAGS  = 4'd1;
  localparam logic [7:0]       FLAG_STOP  = 8'h07;
  localparam logic [3:0]       SHIFT_MAX  = 4'd12;
  localparam logic [3:0]       SHIFT_SUBST = 4'd9;
  localparam logic [3:0]       FILT_MAX   = 4'd4;

  // one data byte handed from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] shift;
    logic [2:0] filter;
    logic       hist_clr;   // zero the history before the low nibble
    logic       stream_end;
  } cmd_t;

  function automatic logic signed [COEF_W-1:0] coef_recent(input logic [2:0] filt);
    logic signed [COEF_W-1:0] c;
    unique case (filt)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_older(input logic [2:0] filt);
    logic signed [COEF_W-1:0] c;
    unique case (filt)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

### design/sabd_front.sv
// Front end: takes stream bytes, tracks block position, header and stop state,
// and pushes data bytes into the queue. Depends on sabd_pkg.
`timescale 1ns / 1ps

module sabd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              stream_first_i,
  input  logic              stream_last_i,
  input  logic              q_full_i,
  output logic              push_o,
  output sabd_pkg::cmd_t    cmd_o
);
  import sabd_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d, pos_eff;
  logic [3:0]       shift_q, shift_d;
  logic [2:0]       filter_q, filter_d;
  logic             stopped_q, stopped_d, stop_eff;
  logic             hclr_q, hclr_d;
  logic             accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // a stream start resets position and stop state before the byte is used
  assign pos_eff  = stream_first_i ? POS_HEADER : pos_q;
  assign stop_eff = stream_first_i ? 1'b0 : stopped_q;

  // classify the byte
  always_comb begin
    pos_d     = pos_q;
    shift_d   = shift_q;
    filter_d  = filter_q;
    stopped_d = stopped_q;
    hclr_d    = hclr_q;
    push_o    = 1'b0;
    if (accept) begin
      pos_d     = pos_eff;
      stopped_d = stop_eff;
      if (stream_first_i) begin
        hclr_d = 1'b1;
      end
      if (!stop_eff) begin
        priority if (pos_eff == POS_HEADER) begin
          shift_d  = (data_byte_i[3:0] > SHIFT_MAX) ? SHIFT_SUBST : data_byte_i[3:0];
          filter_d = (data_byte_i[7:4] > FILT_MAX) ? 3'd0 : data_byte_i[6:4];
        end else if (pos_eff == POS_FLAGS) begin
          if (data_byte_i == FLAG_STOP) begin
            stopped_d = 1'b1;
          end
        end else begin
          push_o = 1'b1;
          hclr_d = 1'b0;
        end
        pos_d = pos_eff + 1'b1;
      end
      if (stream_last_i) begin
        stopped_d = 1'b1;
      end
    end
  end

  assign cmd_o.data       = data_byte_i;
  assign cmd_o.shift      = shift_q;
  assign cmd_o.filter     = filter_q;
  assign cmd_o.hist_clr   = hclr_q;
  assign cmd_o.stream_end = stream_last_i;

  // block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      shift_q   <= '0;
      filter_q  <= '0;
      stopped_q <= 1'b0;
      hclr_q    <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      shift_q   <= shift_d;
      filter_q  <= filter_d;
      stopped_q <= stopped_d;
      hclr_q    <= hclr_d;
    end
  end

endmodule

### design/sabd_queue.sv
// Short FIFO of data-byte items between front and back.
// Depends on sabd_pkg.
`timescale 1ns / 1ps

module sabd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sabd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sabd_pkg::cmd_t cmd_o
);
  import sabd_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !pop_i)
    else $error("queue popped while empty");

endmodule

### design/sabd_back.sv
// Back end: decodes two nibbles per queued byte with the two-tap predictor,
// then rounds and saturates into the output register. Depends on sabd_pkg.
`timescale 1ns / 1ps

module sabd_back #(
  parameter int HIST_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  input  sabd_pkg::cmd_t                     cmd_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [sabd_pkg::SAMP_W-1:0] sample_o,
  output logic                               pair_last_o,
  output logic                               stream_end_o
);
  import sabd_pkg::*;

  localparam int PROD_W = HIST_W + COEF_W;
  localparam int SUM_W  = HIST_W + 3;
  localparam int RND_W  = HIST_W + 2;
  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (HIST_FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] FRAC_MASK = (RND_W'(1) <<< HIST_FRAC_BITS) - 1;

  logic signed [HIST_W-1:0] recent_q, older_q, hr, ho, acc_new;
  logic                     sel_q;
  logic                     en, consume;

  logic [3:0]               nib;
  logic signed [SAMP_W-1:0] d;
  logic signed [SUM_W-1:0]  term, p_r, p_o, sum;
  logic signed [PROD_W-1:0] prod_r, prod_o;

  logic                     s1_valid_q, s1_pair_q, s1_end_q;
  logic signed [HIST_W-1:0] s1_acc_q;

  logic signed [RND_W-1:0]  v, ip;
  logic signed [SAMP_W-1:0] samp_sat;

  logic                     m_valid_q, m_pair_q, m_end_q;
  logic signed [SAMP_W-1:0] m_sample_q;

  // the whole back end advances unless the output register is held
  assign en      = !m_valid_q || out_ready_i;
  assign consume = en && q_valid_i;
  assign pop_o   = consume && sel_q;

  // prediction step for the current nibble
  assign nib = sel_q ? cmd_i.data[7:4] : cmd_i.data[3:0];
  assign hr  = (cmd_i.hist_clr && !sel_q) ? '0 : recent_q;
  assign ho  = (cmd_i.hist_clr && !sel_q) ? '0 : older_q;
  assign d   = $signed({nib, 12'b0}) >>> cmd_i.shift;

  assign prod_r = hr * coef_recent(cmd_i.filter);
  assign prod_o = ho * coef_older(cmd_i.filter);

  always_comb begin
    term = SUM_W'(d) <<< HIST_FRAC_BITS;
    p_r  = SUM_W'(prod_r >>> COEF_SH);
    p_o  = SUM_W'(prod_o >>> COEF_SH);
    sum  = term + p_r + p_o;
    // saturate to the history range
    if (sum[SUM_W-1:HIST_W-1] == '0 || sum[SUM_W-1:HIST_W-1] == '1) begin
      acc_new = sum[HIST_W-1:0];
    end else begin
      acc_new = {sum[SUM_W-1], {(HIST_W-1){!sum[SUM_W-1]}}};
    end
  end

  // round half up, truncate toward zero, saturate to 16 bits
  always_comb begin
    v  = RND_W'(s1_acc_q) + HALF;
    ip = (v[RND_W-1] ? v + FRAC_MASK : v) >>> HIST_FRAC_BITS;
    if (ip[RND_W-1:SAMP_W-1] == '0 || ip[RND_W-1:SAMP_W-1] == '1) begin
      samp_sat = ip[SAMP_W-1:0];
    end else begin
      samp_sat = {ip[RND_W-1], {(SAMP_W-1){!ip[RND_W-1]}}};
    end
  end

  // history, nibble select and valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q   <= '0;
      older_q    <= '0;
      sel_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (consume) begin
        older_q  <= hr;
        recent_q <= acc_new;
        sel_q    <= !sel_q;
      end
      if (en) begin
        s1_valid_q <= q_valid_i;
        m_valid_q  <= s1_valid_q;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_acc_q   <= acc_new;
      s1_pair_q  <= sel_q;
      s1_end_q   <= sel_q && cmd_i.stream_end;
      m_sample_q <= samp_sat;
      m_pair_q   <= s1_pair_q;
      m_end_q    <= s1_end_q;
    end
  end

  assign out_valid_o  = m_valid_q;
  assign sample_o     = m_sample_q;
  assign pair_last_o  = m_pair_q;
  assign stream_end_o = m_end_q;

  a_high_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> q_valid_i)
    else $error("high nibble pending without a queued item");
  a_pop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> !sel_q)
    else $error("nibble select not back on low after pop");
  a_end_on_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_end_q) |-> m_pair_q)
    else $error("stream end flagged on a low-nibble sample");

endmodule

### design/spu_adpcm_block_decoder.sv
// Block ADPCM decoder top level: front end, item queue and decode back end.
// Depends on sabd_pkg, sabd_front, sabd_queue, sabd_back.
// The first sample of a data byte passes through the queue, the first stage register and
// the output register after the byte is accepted. The single prediction unit decodes one
// nibble per cycle while the output register is not held; header bytes are not queued.
// Reset (rst_ni low, asynchronous) clears position, header, stop flag, history, queue.
`timescale 1ns / 1ps

module spu_adpcm_block_decoder #(
  parameter int HIST_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] stream_first
  input  logic        s_axis_tlast,   // stream_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample (signed)
  output logic [0:0]  m_axis_tuser,   // [0] pair_last
  output logic        m_axis_tlast    // stream_end
);
  import sabd_pkg::*;

  cmd_t                     push_cmd, pop_cmd;
  logic                     push, pop, q_full, q_valid;
  logic signed [SAMP_W-1:0] sample;

  sabd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .data_byte_i    (s_axis_tdata),
    .stream_first_i (s_axis_tuser[0]),
    .stream_last_i  (s_axis_tlast),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  sabd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  sabd_back #(
    .HIST_FRAC_BITS (HIST_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .sample_o     (sample),
    .pair_last_o  (m_axis_tuser[0]),
    .stream_end_o (m_axis_tlast)
  );

  assign m_axis_tdata = sample;

endmodule
